[sv/sipl_pkg.sv]
// Shared types and constants for the sorted insert priority list.
// Holds operation and status codes, field widths and the cell control bundle.
// No dependencies.
`default_nettype none

package sipl_pkg;

  localparam int unsigned WeightW      = 24;
  localparam int unsigned TagW         = 16;
  localparam int unsigned PosW         = 6;
  localparam int unsigned CountOutW    = 7;
  localparam int unsigned DefaultDepth = 64;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_POP_MIN = 2'd1,
    MODE_POP_MAX = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/sipl_cell.sv]
// One slot of the sorted list: holds a (weight, tag) entry.
// Shifts up on insert, down on remove-smallest; depends on sipl_pkg.
`default_nettype none

module sipl_cell
  import sipl_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [WeightW-1:0] new_weight,
  input  logic [TagW-1:0]    new_tag,
  input  logic               occupied,
  input  logic               left_after,
  input  logic [WeightW-1:0] left_weight,
  input  logic [TagW-1:0]    left_tag,
  input  logic [WeightW-1:0] right_weight,
  input  logic [TagW-1:0]    right_tag,
  output logic               after,
  output logic [WeightW-1:0] weight,
  output logic [TagW-1:0]    tag
);

  // empty slots count as heavier than anything
  assign after = !occupied || (new_weight < weight);

  always_ff @(posedge clk) begin
    if (ctl.ins && after) begin
      if (left_after) begin
        weight <= left_weight;
        tag    <= left_tag;
      end else begin
        weight <= new_weight;
        tag    <= new_tag;
      end
    end else if (ctl.pop) begin
      weight <= right_weight;
      tag    <= right_tag;
    end
  end

endmodule

`default_nettype wire

[sv/sorted_insert_priority_list_core.sv]
// Top level of the sorted insert priority list: a row of sipl_cell slots,
// the entry count, the read select and the result register; uses sipl_pkg.
//
// Usage:
//   Command channel: drive mode, item_weight, item_tag and position with
//   start high; the beat is taken at the edge where start is high and busy
//   is low. busy never rises, so one operation is taken every cycle.
//   Result channel: done is high for exactly one cycle, in the cycle after the
//   command beat, with out_weight, out_tag, entry_count and status.
//   Throughput is 1 operation per cycle: every slot compares its weight with the
//   new one in parallel and shifts towards its neighbour in the same cycle, and
//   the read select is one mux over the row.
//   Remove-largest and read-at-position take the entry through that mux;
//   remove-smallest takes slot 0 while the row shifts down.
//   Reset clears the entry count and the result strobe; slot contents are
//   left as they are and are only read below the count.
//   The receiver cannot stall: every result must be taken in its cycle.
//   status: ok, empty or position out of range, or full with insert dropped.
`default_nettype none

module sorted_insert_priority_list_core
  import sipl_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic [WeightW-1:0]   item_weight,
  input  logic [TagW-1:0]      item_tag,
  input  logic [PosW-1:0]      position,
  output logic                 done,
  output logic [WeightW-1:0]   out_weight,
  output logic [TagW-1:0]      out_tag,
  output logic [CountOutW-1:0] entry_count,
  output logic [1:0]           status
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  logic [CntW-1:0]    count;
  logic [CntW-1:0]    count_next;
  logic               accept;
  mode_t              op;
  cell_ctl_t          ctl;
  logic               full;
  logic               empty;
  logic [IdxW-1:0]    rd_idx;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   after;
  logic [WeightW-1:0] cell_weight [DEPTH];
  logic [TagW-1:0]    cell_tag    [DEPTH];
  logic [WeightW-1:0] weight_next;
  logic [TagW-1:0]    tag_next;
  status_t            status_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = mode_t'(mode);
  assign full   = (count == CntW'(DEPTH));
  assign empty  = (count == '0);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic               l_after;
    logic [WeightW-1:0] l_weight;
    logic [TagW-1:0]    l_tag;
    logic [WeightW-1:0] r_weight;
    logic [TagW-1:0]    r_tag;

    assign occ[k] = (CntW'(k) < count);

    if (k == 0) begin : g_first
      assign l_after  = 1'b0;
      assign l_weight = item_weight;
      assign l_tag    = item_tag;
    end else begin : g_mid
      assign l_after  = after[k-1];
      assign l_weight = cell_weight[k-1];
      assign l_tag    = cell_tag[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign r_weight = cell_weight[k];
      assign r_tag    = cell_tag[k];
    end else begin : g_inner
      assign r_weight = cell_weight[k+1];
      assign r_tag    = cell_tag[k+1];
    end

    sipl_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .new_weight   (item_weight),
      .new_tag      (item_tag),
      .occupied     (occ[k]),
      .left_after   (l_after),
      .left_weight  (l_weight),
      .left_tag     (l_tag),
      .right_weight (r_weight),
      .right_tag    (r_tag),
      .after        (after[k]),
      .weight       (cell_weight[k]),
      .tag          (cell_tag[k])
    );
  end

  always_comb begin
    ctl         = '0;
    count_next  = count;
    weight_next = '0;
    tag_next    = '0;
    status_next = ST_OK;
    rd_idx      = IdxW'(position);
    unique case (op)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + CntW'(1);
        end
      end
      MODE_POP_MIN: begin
        rd_idx = '0;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.pop     = accept;
          count_next  = count - CntW'(1);
          weight_next = cell_weight[rd_idx];
          tag_next    = cell_tag[rd_idx];
        end
      end
      MODE_POP_MAX: begin
        rd_idx = IdxW'(count - CntW'(1));
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next  = count - CntW'(1);
          weight_next = cell_weight[rd_idx];
          tag_next    = cell_tag[rd_idx];
        end
      end
      MODE_READ: begin
        if (CmpW'(position) < CmpW'(count)) begin
          weight_next = cell_weight[rd_idx];
          tag_next    = cell_tag[rd_idx];
        end else begin
          status_next = ST_EMPTY;
        end
      end
      default: begin
        status_next = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_weight  <= weight_next;
      out_tag     <= tag_next;
      entry_count <= CountOutW'(count_next);
      status      <= status_next;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("command beat without result beat");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> entry_count == CountOutW'(DEPTH))
    else $error("insert dropped while list not full");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (out_weight == '0 && out_tag == '0))
    else $error("error result carries data");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count moved without a command beat");

endmodule

`default_nettype wire

[tb/sv/sorted_insert_priority_list_core_test.sv]
// Self-checking bench for sorted_insert_priority_list_core: a short table of directed
// operations, then phased random traffic, checked beat by beat against a shadow list.
// Depends on sipl_pkg and the core.
`timescale 1ns / 100ps

module sorted_insert_priority_list_core_test;
  import sipl_pkg::*;

  localparam int Depth       = DefaultDepth;
  localparam int RandomItems = 1275;
  localparam int PlanRows    = 25;

  typedef struct packed {
    logic [WeightW-1:0]   weight;
    logic [TagW-1:0]      tag;
    logic [CountOutW-1:0] count;
    status_t              st;
  } reply_t;

  typedef struct packed {
    mode_t              op;
    logic [WeightW-1:0] w;
    logic [TagW-1:0]    t;
    logic [PosW-1:0]    p;
    logic               pinned;
    reply_t             r;
  } plan_row_t;

  localparam reply_t Unpinned = '{24'h0, 16'h0, 7'd0, ST_OK};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           mode = MODE_INSERT;
  logic [WeightW-1:0]   item_weight = '0;
  logic [TagW-1:0]      item_tag = '0;
  logic [PosW-1:0]      position = '0;
  logic                 done;
  logic [WeightW-1:0]   out_weight;
  logic [TagW-1:0]      out_tag;
  logic [CountOutW-1:0] entry_count;
  logic [1:0]           status;

  // typed expectation travelling with the beat, used instead of the shadow list
  logic   pin_on = 1'b0;
  reply_t pin_reply = Unpinned;

  logic [WeightW-1:0] shadow_weight [Depth];
  logic [TagW-1:0]    shadow_tag [Depth];
  int                 shadow_count = 0;
  reply_t             replies_due [$];

  int     faults = 0;
  int     op_tally [4] = '{0, 0, 0, 0};
  int     full_drops = 0;
  int     empty_hits = 0;
  int     peak_count = 0;
  reply_t calc;
  reply_t want;

  plan_row_t plan [PlanRows] = '{
    '{MODE_POP_MIN, 24'hFFFFFF, 16'hFFFF, 6'd63, 1'b1, '{24'h0, 16'h0, 7'd0, ST_EMPTY}},
    '{MODE_POP_MAX, 24'h000000, 16'h0000, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd0, ST_EMPTY}},
    '{MODE_READ,    24'h000000, 16'h0000, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd0, ST_EMPTY}},
    '{MODE_INSERT,  24'hFFFFFF, 16'hFFFF, 6'd63, 1'b1, '{24'h0, 16'h0, 7'd1, ST_OK}},
    '{MODE_INSERT,  24'h000000, 16'h0000, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd2, ST_OK}},
    '{MODE_INSERT,  24'h800000, 16'h1234, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd3, ST_OK}},
    '{MODE_INSERT,  24'h800000, 16'h5678, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd4, ST_OK}},
    '{MODE_INSERT,  24'h000001, 16'hABCD, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd5, ST_OK}},
    '{MODE_READ,    24'h000000, 16'h0000, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd5, ST_OK}},
    '{MODE_READ,    24'h000000, 16'h0000, 6'd1,  1'b0, Unpinned},
    '{MODE_READ,    24'h000000, 16'h0000, 6'd2,  1'b0, Unpinned},
    '{MODE_READ,    24'h000000, 16'h0000, 6'd3,  1'b0, Unpinned},
    '{MODE_READ,    24'h000000, 16'h0000, 6'd4,  1'b1, '{24'hFFFFFF, 16'hFFFF, 7'd5, ST_OK}},
    '{MODE_READ,    24'h000000, 16'h0000, 6'd5,  1'b1, '{24'h0, 16'h0, 7'd5, ST_EMPTY}},
    '{MODE_READ,    24'hFFFFFF, 16'hFFFF, 6'd63, 1'b1, '{24'h0, 16'h0, 7'd5, ST_EMPTY}},
    '{MODE_POP_MAX, 24'h000000, 16'h0000, 6'd0,  1'b1, '{24'hFFFFFF, 16'hFFFF, 7'd4, ST_OK}},
    '{MODE_POP_MIN, 24'h000000, 16'h0000, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd3, ST_OK}},
    '{MODE_POP_MIN, 24'h000000, 16'h0000, 6'd0,  1'b0, Unpinned},
    '{MODE_INSERT,  24'h800000, 16'h9999, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd3, ST_OK}},
    '{MODE_POP_MAX, 24'h000000, 16'h0000, 6'd0,  1'b0, Unpinned},
    '{MODE_POP_MAX, 24'h000000, 16'h0000, 6'd0,  1'b0, Unpinned},
    '{MODE_POP_MIN, 24'h000000, 16'h0000, 6'd0,  1'b0, Unpinned},
    '{MODE_POP_MIN, 24'hFFFFFF, 16'hFFFF, 6'd63, 1'b1, '{24'h0, 16'h0, 7'd0, ST_EMPTY}},
    '{MODE_INSERT,  24'hFFFFFF, 16'h0000, 6'd0,  1'b1, '{24'h0, 16'h0, 7'd1, ST_OK}},
    '{MODE_POP_MAX, 24'h000000, 16'h0000, 6'd0,  1'b1, '{24'hFFFFFF, 16'h0, 7'd0, ST_OK}}
  };

  sorted_insert_priority_list_core #(
    .DEPTH(Depth)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .item_weight(item_weight),
    .item_tag(item_tag),
    .position(position),
    .done(done),
    .out_weight(out_weight),
    .out_tag(out_tag),
    .entry_count(entry_count),
    .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic apply_list_op(input mode_t op, input logic [WeightW-1:0] w,
                               input logic [TagW-1:0] t, input logic [PosW-1:0] p,
                               output reply_t r);
    int at;
    r.weight = '0;
    r.tag    = '0;
    r.st     = ST_OK;
    case (op)
      MODE_INSERT: begin
        if (shadow_count >= Depth) begin
          r.st = ST_FULL;
        end else begin
          at = shadow_count;
          for (int k = shadow_count - 1; k >= 0; k--)
            if (w < shadow_weight[k]) at = k;
          for (int k = shadow_count; k > at; k--) begin
            shadow_weight[k] = shadow_weight[k-1];
            shadow_tag[k]    = shadow_tag[k-1];
          end
          shadow_weight[at] = w;
          shadow_tag[at]    = t;
          shadow_count++;
        end
      end
      MODE_POP_MIN: begin
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.weight = shadow_weight[0];
          r.tag    = shadow_tag[0];
          for (int k = 1; k < shadow_count; k++) begin
            shadow_weight[k-1] = shadow_weight[k];
            shadow_tag[k-1]    = shadow_tag[k];
          end
          shadow_count--;
        end
      end
      MODE_POP_MAX: begin
        if (shadow_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          shadow_count--;
          r.weight = shadow_weight[shadow_count];
          r.tag    = shadow_tag[shadow_count];
        end
      end
      default: begin
        if (int'(p) >= shadow_count) begin
          r.st = ST_EMPTY;
        end else begin
          r.weight = shadow_weight[p];
          r.tag    = shadow_tag[p];
        end
      end
    endcase
    r.count = CountOutW'(shadow_count);
  endtask

  // present one beat after an idle gap and hold it until taken
  task automatic issue(input mode_t op, input logic [WeightW-1:0] w,
                       input logic [TagW-1:0] t, input logic [PosW-1:0] p,
                       input logic pin, input reply_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= op;
    item_weight <= w;
    item_tag    <= t;
    position    <= p;
    pin_on      <= pin;
    pin_reply   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (replies_due.size() == 0) begin
          $error("result beat with no operation outstanding");
          faults++;
        end else begin
          want = replies_due.pop_front();
          if (out_weight !== want.weight) begin
            $error("out_weight: expected %h, got %h", want.weight, out_weight);
            faults++;
          end
          if (out_tag !== want.tag) begin
            $error("out_tag: expected %h, got %h", want.tag, out_tag);
            faults++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            faults++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            faults++;
          end
        end
      end
      if (start && !busy) begin
        apply_list_op(mode_t'(mode), item_weight, item_tag, position, calc);
        replies_due.push_back(pin_on ? pin_reply : calc);
        op_tally[mode]++;
        if (calc.st == ST_FULL) full_drops++;
        if (calc.st == ST_EMPTY) empty_hits++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
    end
  end

  initial begin
    int            phase_kind;
    int            phase_len;
    int            issued;
    int            roll;
    int            gap;
    int            level_hint;
    int            settle;
    bit            calm;
    mode_t         op;
    logic [WeightW-1:0] w;
    logic [PosW-1:0]    p;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      issue(plan[i].op, plan[i].w, plan[i].t, plan[i].p, plan[i].pinned, plan[i].r,
            $urandom_range(0, 19));

    // open with a pure fill past capacity, then mix phases of differing bias
    issued     = 0;
    level_hint = 0;
    phase_kind = 4;
    phase_len  = 72;
    while (issued < RandomItems) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_len && issued < RandomItems; n++) begin
        roll = $urandom_range(0, 99);
        case (phase_kind)
          0: op = roll < 85 ? MODE_INSERT : roll < 90 ? MODE_READ :
                  roll < 95 ? MODE_POP_MIN : MODE_POP_MAX;
          1: op = roll < 20 ? MODE_INSERT : roll < 30 ? MODE_READ :
                  roll < 65 ? MODE_POP_MIN : MODE_POP_MAX;
          2: op = roll < 45 ? MODE_INSERT : roll < 70 ? MODE_READ :
                  roll < 85 ? MODE_POP_MIN : MODE_POP_MAX;
          3: op = roll < 15 ? MODE_INSERT : roll < 85 ? MODE_READ :
                  roll < 93 ? MODE_POP_MIN : MODE_POP_MAX;
          default: op = MODE_INSERT;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 40) w = WeightW'($urandom());
        else if (roll < 70) w = WeightW'($urandom_range(0, 7));
        else if (roll < 85) w = WeightW'($urandom_range(0, 255));
        else w = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        if ($urandom_range(0, 3) != 0)
          p = PosW'($urandom_range(0, level_hint < 63 ? level_hint : 63));
        else
          p = PosW'($urandom());
        if (op == MODE_INSERT && level_hint < Depth) level_hint++;
        if ((op == MODE_POP_MIN || op == MODE_POP_MAX) && level_hint > 0) level_hint--;
        gap = calm ? 0 : $urandom_range(0, 19);
        issue(op, w, TagW'($urandom()), p, 1'b0, Unpinned, gap);
        issued++;
      end
      phase_kind = $urandom_range(0, 3);
      phase_len  = $urandom_range(20, 150);
    end
    start <= 1'b0;

    for (settle = 0; settle < 50 && replies_due.size() != 0; settle++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d results never arrived", replies_due.size());
      faults++;
    end

    $display("ops: %0d insert, %0d remove-smallest, %0d remove-largest, %0d read",
             op_tally[MODE_INSERT], op_tally[MODE_POP_MIN], op_tally[MODE_POP_MAX],
             op_tally[MODE_READ]);
    $display("inserts dropped when full: %0d, empty or out-of-range: %0d, peak fill: %0d",
             full_drops, empty_hits, peak_count);
    if (faults == 0)
      $display("sorted_insert_priority_list_core_test: clean");
    else
      $display("sorted_insert_priority_list_core_test: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("timed out");
    $display("sorted_insert_priority_list_core_test: errors");
    $finish;
  end

endmodule
